// ----- src/lif_spiking_network_stdp_top_defines.svh -----
// Assertion macros for the spiking network block checker.
`ifndef LIF_SPIKING_NETWORK_STDP_TOP_DEFINES_SVH
`define LIF_SPIKING_NETWORK_STDP_TOP_DEFINES_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define LSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsn_checker: next-cycle property failed");

// Check that the consequent holds in the same cycle as the antecedent.
`define LSN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsn_checker: same-cycle property failed");

`endif

// ----- src/lsn_pkg.sv -----
// Shared constants, codes and saturating arithmetic for the spiking network block.
`timescale 1ns / 1ps

package lsn_pkg;

  // Network size and number format
  localparam int NEURONS       = 16;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_W         = $clog2(NEURONS);
  localparam int PAIRS         = 1 << (2 * IDX_W);
  localparam int REPORTED      = (NEURONS < 16) ? NEURONS : 16;

  localparam int VAL_W     = 24;
  localparam int LEAK_W    = 17;
  localparam int LEAK_BITS = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Learning step of 0.01, rounded to the fraction grid
  localparam int LEARN_STEP = ((1 << FRACTION_BITS) + 50) / 100;
  localparam logic signed [VAL_W-1:0] STEP_POS = VAL_W'(LEARN_STEP);
  localparam logic signed [VAL_W-1:0] STEP_NEG = VAL_W'(-LEARN_STEP);

  localparam logic signed [VAL_W-1:0] THR_RESET  = VAL_W'(65536);
  localparam logic [LEAK_W-1:0]       LEAK_RESET = LEAK_W'(58982);

  typedef enum logic [1:0] {
    ACT_STIM = 2'd0,
    ACT_TICK = 2'd1,
    ACT_LOAD = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_LEAK      = 1'b1
  } cfg_e;

  // Add two values and clip to the signed range
  function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

endpackage

// ----- src/lif_spiking_network_stdp_top.sv -----
// Top level of the leaky integrate-and-fire network with spike-timing learning.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------------------------
//  input     | in_valid_i / in_stall_o      | action_i, neuron_index_i, target_index_i,
//            |                              | amount_i
//  output    | out_valid_o / out_stall_i    | out_neuron_o, out_potential_o,
//            |                              | out_spiked_o, last_o
//  config    | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//
// Stimulate and load words are applied while the block stays idle. A tick runs fire/leak
// (one leak multiplier; a multiply state, then a write state per neuron), then transmit and
// learn over every source/target pair (one weight memory read per cycle), then a report of
// REPORTED words, which waits while the output side stalls.
// Reset clears potentials, spike flags and weight valid bits and loads the configuration
// reset values at once; there is no clearing pass. The block accepts no word while a tick is in work.
`timescale 1ns / 1ps

module lif_spiking_network_stdp_top
  import lsn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic [3:0]              neuron_index_i,
  input  logic [3:0]              target_index_i,
  input  logic signed [VAL_W-1:0] amount_i,
  // output channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [3:0]              out_neuron_o,
  output logic signed [VAL_W-1:0] out_potential_o,
  output logic                    out_spiked_o,
  output logic                    last_o
);

  localparam int PW    = 2 * IDX_W + 1;
  localparam int PRODW = VAL_W + LEAK_W;
  localparam int RW    = PRODW - LEAK_BITS + 1;
  localparam logic [PRODW:0]  RND_HALF  = (PRODW + 1)'(1) << (LEAK_BITS - 1);
  localparam logic [RW-1:0]   R_POS_LIM = RW'((1 << (VAL_W - 1)) - 1);
  localparam logic [RW-1:0]   R_NEG_LIM = RW'(1 << (VAL_W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRE_MUL,
    S_FIRE_WR,
    S_XFER,
    S_REPORT
  } state_e;

  // configuration registers
  logic signed [VAL_W-1:0] thr_q;
  logic [LEAK_W-1:0]       leak_q;

  // sequencer and neuron state
  state_e                  state_q, state_d;
  logic [PW-1:0]           cnt_q, cnt_d;
  logic signed [VAL_W-1:0] pot_q [NEURONS];
  logic signed [VAL_W-1:0] pot_d [NEURONS];
  logic [NEURONS-1:0]      flag_q, flag_d;

  // leak multiplier stage
  logic [PRODW-1:0]        prod_q, prod_d;
  logic                    neg_q, neg_d;
  logic                    ge_q, ge_d;

  // weight memory and its valid bits
  logic signed [VAL_W-1:0] wmem [PAIRS];
  logic [PAIRS-1:0]        wvld_q;
  logic signed [VAL_W-1:0] rd_w_q;
  logic                    rd_ok_q;
  logic                    mem_we;
  logic [2*IDX_W-1:0]      mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [2*IDX_W-1:0]      mem_raddr;

  // transmit/learn stage after the memory read
  logic                    sv_q, sv_d;
  logic [IDX_W-1:0]        bs_q, bs_d;
  logic [IDX_W-1:0]        bt_q, bt_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [3:0]              out_neuron_q, out_neuron_d;
  logic signed [VAL_W-1:0] out_pot_q, out_pot_d;
  logic                    out_spk_q, out_spk_d;
  logic                    out_last_q, out_last_d;

  // datapath signals
  logic                    in_acc;
  logic [IDX_W-1:0]        in_src;
  logic [IDX_W-1:0]        in_tgt;
  logic                    src_ok;
  logic                    tgt_ok;
  logic [IDX_W-1:0]        rd_idx;
  logic signed [VAL_W-1:0] pot_rd;
  logic signed [VAL_W-1:0] add_b;
  logic signed [VAL_W-1:0] add_sum;
  logic signed [VAL_W-1:0] w_b;
  logic                    xfer_act;
  logic signed [VAL_W-1:0] learn_w;
  logic [VAL_W-1:0]        mag;
  logic [PRODW:0]          rnd;
  logic [RW-1:0]           rmag;
  logic signed [VAL_W-1:0] leak_val;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_src     = IDX_W'(neuron_index_i);
  assign in_tgt     = IDX_W'(target_index_i);
  assign src_ok     = 32'(neuron_index_i) < NEURONS;
  assign tgt_ok     = 32'(target_index_i) < NEURONS;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      leak_q <= LEAK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q  <= cfg_data_i[VAL_W-1:0];
        CFG_LEAK:      leak_q <= cfg_data_i[LEAK_W-1:0];
      endcase
    end
  end

  // Select the one potential the sequencer works on this cycle
  always_comb begin
    case (state_q)
      S_FIRE_MUL, S_FIRE_WR, S_REPORT: rd_idx = cnt_q[IDX_W-1:0];
      S_XFER:                          rd_idx = bt_q;
      default:                         rd_idx = in_src;
    endcase
  end
  assign pot_rd = pot_q[rd_idx];

  // Shared saturating adder: stimulus in idle, weight during transmit
  assign w_b     = rd_ok_q ? rd_w_q : '0;
  assign add_b   = (state_q == S_XFER) ? w_b : amount_i;
  assign add_sum = sat_add(pot_rd, add_b);

  // Transmit and learn apply only for a spiking source and a distinct target
  assign xfer_act = sv_q && (32'(bs_q) < NEURONS) && (32'(bt_q) < NEURONS) &&
                    (bs_q != bt_q) && flag_q[bs_q];
  assign learn_w  = sat_add(w_b, flag_q[bt_q] ? STEP_POS : STEP_NEG);

  // Leak: magnitude times factor, round half away from zero, clip
  assign mag  = pot_rd[VAL_W-1] ? VAL_W'(-pot_rd) : VAL_W'(pot_rd);
  assign rnd  = {1'b0, prod_q} + RND_HALF;
  assign rmag = RW'(rnd >> LEAK_BITS);
  always_comb begin
    if (neg_q) begin
      leak_val = (rmag > R_NEG_LIM) ? VAL_MIN : -$signed(rmag[VAL_W-1:0]);
    end else begin
      leak_val = (rmag > R_POS_LIM) ? VAL_MAX : $signed(rmag[VAL_W-1:0]);
    end
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pot_d        = pot_q;
    flag_d       = flag_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    ge_d         = ge_q;
    sv_d         = 1'b0;
    bs_d         = bs_q;
    bt_d         = bt_q;
    out_valid_d  = out_valid_q;
    out_neuron_d = out_neuron_q;
    out_pot_d    = out_pot_q;
    out_spk_d    = out_spk_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = {in_src, in_tgt};
    mem_wdata    = amount_i;
    mem_raddr    = cnt_q[2*IDX_W-1:0];

    // drop a result word once it is taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // finish the transmit/learn step for the pair read last cycle
    if (xfer_act) begin
      pot_d[bt_q] = add_sum;
      if (w_b > 0) begin
        mem_we    = 1'b1;
        mem_waddr = {bs_q, bt_q};
        mem_wdata = learn_w;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (action_i)
            ACT_STIM: begin
              if (src_ok) begin
                pot_d[in_src] = add_sum;
              end
            end
            ACT_LOAD: begin
              if (src_ok && tgt_ok && (neuron_index_i != target_index_i)) begin
                mem_we = 1'b1;
              end
            end
            ACT_TICK: begin
              state_d = S_FIRE_MUL;
              cnt_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_FIRE_MUL: begin
        ge_d    = pot_rd >= thr_q;
        neg_d   = pot_rd[VAL_W-1];
        prod_d  = PRODW'(mag) * PRODW'(leak_q);
        state_d = S_FIRE_WR;
      end
      S_FIRE_WR: begin
        flag_d[rd_idx] = ge_q;
        pot_d[rd_idx]  = ge_q ? '0 : leak_val;
        if (cnt_q[IDX_W-1:0] == IDX_W'(NEURONS - 1)) begin
          state_d = S_XFER;
          cnt_d   = '0;
        end else begin
          state_d = S_FIRE_MUL;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      S_XFER: begin
        // issue one weight read per cycle, source-major order
        if (cnt_q < PW'(PAIRS)) begin
          sv_d  = 1'b1;
          bs_d  = cnt_q[2*IDX_W-1:IDX_W];
          bt_d  = cnt_q[IDX_W-1:0];
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = S_REPORT;
          cnt_d   = '0;
        end
      end
      S_REPORT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_neuron_d = 4'(rd_idx);
          out_pot_d    = pot_rd;
          out_spk_d    = flag_q[rd_idx];
          out_last_d   = (rd_idx == IDX_W'(REPORTED - 1));
          if (rd_idx == IDX_W'(REPORTED - 1)) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold sequencer, neuron state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      flag_q       <= '0;
      sv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      out_neuron_q <= '0;
      out_pot_q    <= '0;
      out_spk_q    <= 1'b0;
      out_last_q   <= 1'b0;
      for (int i = 0; i < NEURONS; i++) begin
        pot_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      flag_q       <= flag_d;
      sv_q         <= sv_d;
      out_valid_q  <= out_valid_d;
      out_neuron_q <= out_neuron_d;
      out_pot_q    <= out_pot_d;
      out_spk_q    <= out_spk_d;
      out_last_q   <= out_last_d;
      pot_q        <= pot_d;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
    ge_q   <= ge_d;
    bs_q   <= bs_d;
    bt_q   <= bt_d;
  end

  // Weight memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wmem[mem_waddr] <= mem_wdata;
    end
    rd_w_q <= wmem[mem_raddr];
  end

  // Weight valid bits: an unwritten weight reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q  <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (mem_we) begin
        wvld_q[mem_waddr] <= 1'b1;
      end
      rd_ok_q <= wvld_q[mem_raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_neuron_o    = out_neuron_q;
  assign out_potential_o = out_pot_q;
  assign out_spiked_o    = out_spk_q;
  assign last_o          = out_last_q;

endmodule

// ----- src/lsn_checker.sv -----
// Port-level checker for the spiking network block, bound to its top level.
`timescale 1ns / 1ps
`include "lif_spiking_network_stdp_top_defines.svh"

module lsn_checker
  import lsn_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [CFG_IDX_W-1:0]    cfg_index_i,
  input logic [CFG_W-1:0]        cfg_data_i,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [1:0]              action_i,
  input logic [3:0]              neuron_index_i,
  input logic [3:0]              target_index_i,
  input logic signed [VAL_W-1:0] amount_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [3:0]              out_neuron_o,
  input logic signed [VAL_W-1:0] out_potential_o,
  input logic                    out_spiked_o,
  input logic                    last_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result word holds
  `LSN_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_neuron_o) && $stable(out_potential_o) && $stable(out_spiked_o) && $stable(last_o))

  // A tick makes the block busy in the next cycle
  `LSN_ASSERT_NEXT(a_tick_busy, in_acc && (action_i == ACT_TICK), in_stall_o)

  // Other words leave the block idle in the next cycle
  `LSN_ASSERT_NEXT(a_short_word, in_acc && (action_i != ACT_TICK), !in_stall_o)

  // Nothing follows the last word of a tick right away
  `LSN_ASSERT_NEXT(a_last_ends, out_valid_o && !out_stall_i && last_o, !out_valid_o)

endmodule

bind lif_spiking_network_stdp_top lsn_checker u_lsn_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the spiking network top: directed table, then random words.
`timescale 1ns / 1ps

module testbench;
  import lsn_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TICK_SETTLE  = 320;
  localparam int RANDOM_WORDS = 140;
  localparam int PHASES       = 4;
  localparam int LEAK_SHIFT   = 16;
  localparam int STDP_STEP    = ((1 << FRACTION_BITS) + 50) / 100;
  localparam longint Q_MAX    = (64'sd1 <<< (VAL_W - 1)) - 1;
  localparam longint Q_MIN    = -Q_MAX - 1;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0]              neuron;
    logic signed [VAL_W-1:0] potential;
    logic                    spiked;
    logic                    last;
  } report_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [1:0]              act;
    cfg_e                    cfg_sel;
    logic [3:0]              src;
    logic [3:0]              dst;
    logic signed [VAL_W-1:0] amt;        // word amount, or register value
    logic                    pinned;     // typed expectation for one neuron
    logic [3:0]              pin_neuron;
    logic signed [VAL_W-1:0] pin_pot;
    logic                    pin_spk;
  } stim_row_t;

  // Directed words and register writes, with a typed expectation where obvious
  //   kind      act         register       src    dst    amount         pin   n     pot  spk
  localparam stim_row_t SCRIPT [25] = '{
    '{ROW_WORD, ACT_TICK,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd0,        1'b1, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd0,  4'd9,  24'sh7FFFFF,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sh7FFFFF,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd1,  4'd15, 24'sh800000,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd1,  4'd0,  -24'sd1,       1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_LOAD,   CFG_THRESHOLD, 4'd0,  4'd1,  24'sh7FFFFF,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_LOAD,   CFG_THRESHOLD, 4'd0,  4'd2,  24'sh800000,   1'b0, 4'd0, 24'sd0, 1'b0},
    // self connection: dropped
    '{ROW_WORD, ACT_LOAD,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd12345,    1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_LOAD,   CFG_THRESHOLD, 4'd15, 4'd0,  24'sd655,      1'b0, 4'd0, 24'sd0, 1'b0},
    // unused action code: no effect, no results
    '{ROW_WORD, ACT_UNUSED, CFG_THRESHOLD, 4'd5,  4'd6,  24'sd1000,     1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_TICK,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd0,        1'b1, 4'd0, 24'sd0, 1'b1},
    // leak above one saturates a negative potential
    '{ROW_CFG,  ACT_STIM,   CFG_LEAK,      4'd0,  4'd0,  24'sd131071,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_TICK,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd0,        1'b1, 4'd2,
      24'sh800000, 1'b0},
    // lowest threshold: every neuron fires
    '{ROW_CFG,  ACT_STIM,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sh800000,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_TICK,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd0,        1'b1, 4'd5, 24'sd0, 1'b1},
    '{ROW_CFG,  ACT_STIM,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sh7FFFFF,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_CFG,  ACT_STIM,   CFG_LEAK,      4'd0,  4'd0,  24'sd0,        1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd4,  4'd3,  24'sh7FFFFF,   1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd6,  4'd0,  -24'sd5000,    1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_TICK,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd0,        1'b1, 4'd6, 24'sd0, 1'b0},
    '{ROW_CFG,  ACT_STIM,   CFG_LEAK,      4'd0,  4'd0,  24'sd65536,    1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_CFG,  ACT_STIM,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd65536,    1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd7,  4'd0,  -24'sd3,       1'b0, 4'd0, 24'sd0, 1'b0},
    '{ROW_WORD, ACT_TICK,   CFG_THRESHOLD, 4'd0,  4'd0,  24'sd0,        1'b1, 4'd7,
      -24'sd3, 1'b0},
    '{ROW_WORD, ACT_STIM,   CFG_THRESHOLD, 4'd8,  4'd0,  24'sd70000,    1'b0, 4'd0, 24'sd0, 1'b0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              action_i;
  logic [3:0]              neuron_index_i;
  logic [3:0]              target_index_i;
  logic signed [VAL_W-1:0] amount_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [3:0]              out_neuron_o;
  logic signed [VAL_W-1:0] out_potential_o;
  logic                    out_spiked_o;
  logic                    last_o;

  // Network state as the testbench sees it
  logic signed [VAL_W-1:0] pot_m [NEURONS];
  logic                    spk_m [NEURONS];
  logic signed [VAL_W-1:0] wgt_m [NEURONS][NEURONS];
  logic signed [VAL_W-1:0] thr_m;
  logic [LEAK_W-1:0]       leak_m;

  report_t pending_reports [$];
  int      mismatch_count;
  int      cycle_count;
  bit      in_gaps_on;
  bit      out_stalls_on;

  lif_spiking_network_stdp_top i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up after a generous number of cycles
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] clip(input longint v);
    if (v > Q_MAX) return VAL_W'(Q_MAX);
    if (v < Q_MIN) return VAL_W'(Q_MIN);
    return VAL_W'(v);
  endfunction

  // Scale by the leak factor, rounding half away from zero
  function automatic logic signed [VAL_W-1:0] leaked(input logic signed [VAL_W-1:0] p,
                                                     input logic [LEAK_W-1:0] f);
    longint mag;
    longint prod;
    mag  = (p < 0) ? -longint'(p) : longint'(p);
    prod = (mag * longint'(f) + (64'sd1 <<< (LEAK_SHIFT - 1))) >>> LEAK_SHIFT;
    return clip((p < 0) ? -prod : prod);
  endfunction

  task automatic reset_network();
    for (int s = 0; s < NEURONS; s++) begin
      pot_m[s] = '0;
      spk_m[s] = 1'b0;
      for (int t = 0; t < NEURONS; t++) wgt_m[s][t] = '0;
    end
    thr_m  = THR_RESET;
    leak_m = LEAK_RESET;
  endtask

  // Advance the network by one accepted word and queue the reports it causes
  task automatic advance_network(input logic [1:0] act, input logic [3:0] src,
                                 input logic [3:0] dst, input logic signed [VAL_W-1:0] amt);
    report_t r;
    case (act)
      ACT_STIM: pot_m[src] = clip(longint'(pot_m[src]) + longint'(amt));
      ACT_LOAD: if (src != dst) wgt_m[src][dst] = amt;
      ACT_TICK: begin
        // fire or leak
        for (int s = 0; s < NEURONS; s++) begin
          spk_m[s] = (pot_m[s] >= thr_m);
          pot_m[s] = spk_m[s] ? '0 : leaked(pot_m[s], leak_m);
        end
        // transmit, sources then targets in ascending order
        for (int s = 0; s < NEURONS; s++) begin
          if (spk_m[s]) begin
            for (int t = 0; t < NEURONS; t++) begin
              if (t != s) pot_m[t] = clip(longint'(pot_m[t]) + longint'(wgt_m[s][t]));
            end
          end
        end
        // learn on positive weights of firing sources
        for (int s = 0; s < NEURONS; s++) begin
          if (spk_m[s]) begin
            for (int t = 0; t < NEURONS; t++) begin
              if (t != s && wgt_m[s][t] > 0) begin
                wgt_m[s][t] = clip(longint'(wgt_m[s][t]) +
                                   (spk_m[t] ? STDP_STEP : -STDP_STEP));
              end
            end
          end
        end
        for (int s = 0; s < REPORTED; s++) begin
          r.neuron    = 4'(s);
          r.potential = pot_m[s];
          r.spiked    = spk_m[s];
          r.last      = (s == REPORTED - 1);
          pending_reports.insert(pending_reports.size(), r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Present one word after a random gap and hold it until accepted
  task automatic send_word(input logic [1:0] act, input logic [3:0] src,
                           input logic [3:0] dst, input logic signed [VAL_W-1:0] amt);
    int gap;
    gap = in_gaps_on ? $urandom_range(7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    neuron_index_i <= src;
    target_index_i <= dst;
    amount_i       <= amt;
    do @(posedge clk_i); while (in_stall_o);
    advance_network(act, src, dst, amt);
  endtask

  // Stop sending, wait for every queued report, then let the block settle
  task automatic drain(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_e sel, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      CFG_THRESHOLD: thr_m = data[VAL_W-1:0];
      CFG_LEAK:      leak_m = data[LEAK_W-1:0];
      default: ;
    endcase
  endtask

  // Stall the output side for a random number of cycles before each word
  initial begin
    int hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      hold = out_stalls_on ? $urandom_range(7) : 0;
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each accepted report with the oldest one queued
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected word for neuron %0d", out_neuron_o));
      end else begin
        want = pending_reports.pop_front();
        if (out_neuron_o !== want.neuron)
          note_mismatch($sformatf("neuron index: got %0d, want %0d", out_neuron_o, want.neuron));
        if (out_potential_o !== want.potential)
          note_mismatch($sformatf("neuron %0d potential: got %0d, want %0d", want.neuron,
                                  out_potential_o, $signed(want.potential)));
        if (out_spiked_o !== want.spiked)
          note_mismatch($sformatf("neuron %0d spike flag: got %0b, want %0b", want.neuron,
                                  out_spiked_o, want.spiked));
        if (last_o !== want.last)
          note_mismatch($sformatf("neuron %0d last flag: got %0b, want %0b", want.neuron,
                                  last_o, want.last));
      end
    end
  end

  initial begin
    int                      counted;
    int                      pick;
    int                      k;
    bit                      paused;
    logic [1:0]              act;
    logic [3:0]              src;
    logic [3:0]              dst;
    logic signed [VAL_W-1:0] amt;
    logic signed [VAL_W-1:0] thr_pick;
    logic [LEAK_W-1:0]       leak_pick;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_THRESHOLD;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    action_i       = ACT_STIM;
    neuron_index_i = '0;
    target_index_i = '0;
    amount_i       = '0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    mismatch_count = 0;
    cycle_count    = 0;
    counted        = 0;
    paused         = 1'b0;
    reset_network();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < $size(SCRIPT); i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        drain(TICK_SETTLE);
        write_register(SCRIPT[i].cfg_sel, SCRIPT[i].amt);
      end else begin
        send_word(SCRIPT[i].act, SCRIPT[i].src, SCRIPT[i].dst, SCRIPT[i].amt);
        if (SCRIPT[i].pinned) begin
          k = pending_reports.size() - REPORTED + SCRIPT[i].pin_neuron;
          pending_reports[k].potential = SCRIPT[i].pin_pot;
          pending_reports[k].spiked    = SCRIPT[i].pin_spk;
        end
      end
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain(TICK_SETTLE);
      in_gaps_on    = (phase != 1) && ($urandom_range(3) != 0);
      out_stalls_on = (phase != 1) && ($urandom_range(3) != 0);
      case ($urandom_range(4))
        0:       thr_pick = VAL_W'($urandom());
        1:       thr_pick = VAL_W'(-$urandom_range(65536));
        default: thr_pick = VAL_W'($urandom_range(16384, 262144));
      endcase
      leak_pick = ($urandom_range(3) == 0) ? LEAK_W'($urandom_range(131071))
                                           : LEAK_W'($urandom_range(32768, 65536));
      write_register(CFG_THRESHOLD, thr_pick);
      write_register(CFG_LEAK, CFG_W'(leak_pick));

      while (counted < (phase + 1) * RANDOM_WORDS / PHASES) begin
        // hold off once mid-run until every report is in
        if (phase == 2 && !paused && counted >= RANDOM_WORDS / 2 + RANDOM_WORDS / 8) begin
          drain(0);
          paused = 1'b1;
        end
        src  = 4'($urandom_range(15));
        dst  = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 40) begin
          act = ACT_STIM;
          amt = ($urandom_range(4) == 0) ? VAL_W'($urandom())
                                         : VAL_W'($urandom_range(163840) - 32768);
        end else if (pick < 64) begin
          act = ACT_TICK;
          amt = VAL_W'($urandom());
        end else if (pick < 96) begin
          act = ACT_LOAD;
          case ($urandom_range(9))
            6:       amt = $urandom_range(1) ? VAL_W'(STDP_STEP) : VAL_W'($urandom_range(1));
            7:       amt = VAL_W'(-$urandom_range(1, 131072));
            8:       amt = VAL_W'(24'h7FFFFF - $urandom_range(2000));
            9:       amt = VAL_W'($urandom());
            default: amt = VAL_W'($urandom_range(1, 131072));
          endcase
        end else begin
          act = ACT_UNUSED;
          amt = VAL_W'($urandom());
        end
        send_word(act, src, dst, amt);
        if (act != ACT_UNUSED && !(act == ACT_LOAD && src == dst)) counted++;
      end
    end

    drain(TICK_SETTLE);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
